// ===== hw/rtl/swkd_pkg.sv =====
// swkd_pkg: constants, register indexes and the seven-segment table
// for the stopwatch keypad display scanner; no dependencies

package swkd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DISP_SLOTS  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TICKS   = 2'd1;

    localparam logic [15:0] TICKS_RESET   = 16'd1000;
    localparam logic [7:0]  RELEASE_RESET = 8'd32;
    localparam logic [5:0]  PRESS_IDLE    = 6'd33;

    localparam logic [3:0] KEY_START = 4'd10;
    localparam logic [3:0] KEY_STOP  = 4'd11;
    localparam logic [3:0] KEY_CLEAR = 4'd12;

    function automatic logic [7:0] seg_pattern(input logic [3:0] code);
        logic [7:0] pat;
        begin
            case (code)
                4'd0:    pat = 8'hfc;
                4'd1:    pat = 8'h60;
                4'd2:    pat = 8'hda;
                4'd3:    pat = 8'hf2;
                4'd4:    pat = 8'h66;
                4'd5:    pat = 8'hb6;
                4'd6:    pat = 8'hbe;
                4'd7:    pat = 8'he0;
                4'd8:    pat = 8'hfe;
                4'd9:    pat = 8'he6;
                4'd10:   pat = 8'h00;
                default: pat = 8'hff;
            endcase
            return pat;
        end
    endfunction

endpackage

// ===== hw/rtl/stopwatch_keypad_display_scanner.sv =====
// stopwatch_keypad_display_scanner: 4x4 keypad scan, debounce, buzzer,
// multiplexed display drive and bcd stopwatch; uses swkd_pkg
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    return_lines
// out      out  out_valid / out_ready  digit_select .. pressed_key
// cfg      in   cfg_write              cfg_index, cfg_data
//
// one tick beat is processed per clock when not stalled; non-config state
// updates at accept; the result is visible the next cycle from state registers
// a new beat is taken whenever the result register is empty or being drained
// out_ready low holds the result and stalls the input side
// asynchronous active-low reset restores all state and both config registers

module stopwatch_keypad_display_scanner #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0]                          return_lines,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3:0]                          digit_select,
    output logic [7:0]                          segment_pattern,
    output logic                                buzzer_level,
    output logic                                running,
    output logic [15:0]                         count_bcd,
    output logic                                key_accepted,
    output logic [3:0]                          pressed_key,
    input  logic                                cfg_write,
    input  logic [swkd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swkd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [15:0] ticks_per_count_reg;
    logic [7:0]  release_ticks_reg;

    logic [3:0]  scan_position_reg;
    logic [5:0]  press_counter_reg,   press_counter_next;
    logic [3:0]  latched_key_reg,     latched_key_next;
    logic        key_held_reg,        key_held_next;
    logic [7:0]  release_counter_reg, release_counter_next;
    logic        buzzer_enable_reg,   buzzer_enable_next;
    logic        buzzer_state_reg;
    logic        run_flag_reg,        run_flag_next;
    logic [3:0]  digits_reg [NUM_DIGITS];
    logic [3:0]  digits_next [NUM_DIGITS];
    logic [15:0] second_counter_reg,  second_counter_next;
    logic        second_due_reg;
    logic [3:0]  select_port_reg,     select_port_next;
    logic [7:0]  segment_port_reg,    segment_port_next;
    logic        accepted_reg,        accepted_next;
    logic        out_valid_reg;

    logic        accept;
    logic [1:0]  slot;
    logic        line_low;
    logic        due_now;
    logic [15:0] second_dec;
    logic [5:0]  press_dec;
    logic [7:0]  release_dec;
    logic        carry;
    logic [3:0]  digit_inc;

    logic [3:0]  slot_code [swkd_pkg::DISP_SLOTS];
    logic        slot_live [swkd_pkg::DISP_SLOTS];
    logic [3:0]  bcd_view  [swkd_pkg::DISP_SLOTS];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign slot     = scan_position_reg[3:2];
    assign line_low = !return_lines[scan_position_reg[1:0]];

    for (genvar g = 0; g < swkd_pkg::DISP_SLOTS; g++) begin : g_slot
        if (g < NUM_DIGITS) begin : g_live
            assign slot_code[g] = digits_reg[g];
            assign slot_live[g] = 1'b1;
            assign bcd_view[g]  = digits_reg[g];
        end else begin : g_dead
            assign slot_code[g] = 4'd0;
            assign slot_live[g] = 1'b0;
            assign bcd_view[g]  = 4'd0;
        end
    end

    // second timer
    always_comb
    begin
        second_dec          = second_counter_reg - 16'd1;
        second_counter_next = second_counter_reg;
        due_now             = second_due_reg;
        if (!second_due_reg)
        begin
            if (second_dec == 16'd0)
            begin
                second_counter_next = ticks_per_count_reg;
                due_now             = 1'b1;
            end
            else
            begin
                second_counter_next = second_dec;
            end
        end
    end

    // display drive
    always_comb
    begin
        select_port_next  = select_port_reg;
        segment_port_next = segment_port_reg;
        if (scan_position_reg[1:0] == 2'd0)
        begin
            if (slot_live[slot])
            begin
                select_port_next  = ~(4'd1 << slot);
                segment_port_next = swkd_pkg::seg_pattern(slot_code[slot]);
            end
            else
            begin
                select_port_next  = 4'hf;
                segment_port_next = 8'h00;
            end
        end
        else if (scan_position_reg[1:0] == 2'd3)
        begin
            segment_port_next = 8'h00;
        end
    end

    // key debounce and release
    always_comb
    begin
        press_dec            = press_counter_reg - 6'd1;
        release_dec          = release_counter_reg - 8'd1;
        press_counter_next   = press_counter_reg;
        latched_key_next     = latched_key_reg;
        key_held_next        = key_held_reg;
        release_counter_next = release_counter_reg;
        buzzer_enable_next   = buzzer_enable_reg;
        accepted_next        = 1'b0;
        if (!key_held_reg)
        begin
            if (press_counter_reg == swkd_pkg::PRESS_IDLE)
            begin
                if (line_low)
                begin
                    press_counter_next = swkd_pkg::PRESS_IDLE - 6'd1;
                    latched_key_next   = scan_position_reg;
                end
            end
            else if (press_dec == 6'd0)
            begin
                press_counter_next = swkd_pkg::PRESS_IDLE;
                if (line_low)
                begin
                    key_held_next      = 1'b1;
                    buzzer_enable_next = 1'b1;
                    accepted_next      = 1'b1;
                end
            end
            else
            begin
                press_counter_next = press_dec;
            end
        end
        else if (line_low)
        begin
            release_counter_next = release_ticks_reg;
        end
        else if (release_dec == 8'd0)
        begin
            buzzer_enable_next   = 1'b0;
            release_counter_next = release_ticks_reg;
            key_held_next        = 1'b0;
        end
        else
        begin
            release_counter_next = release_dec;
        end
    end

    // counter step and key action
    always_comb
    begin
        carry         = due_now && run_flag_reg;
        digit_inc     = 4'd0;
        run_flag_next = run_flag_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit_inc      = digits_reg[i] + 4'd1;
            digits_next[i] = digits_reg[i];
            if (carry)
            begin
                if (digit_inc <= 4'd9)
                begin
                    digits_next[i] = digit_inc;
                    carry          = 1'b0;
                end
                else
                begin
                    digits_next[i] = 4'd0;
                end
            end
        end
        if (accepted_next)
        begin
            unique case (latched_key_next)
                swkd_pkg::KEY_START: run_flag_next = 1'b1;
                swkd_pkg::KEY_STOP:  run_flag_next = 1'b0;
                swkd_pkg::KEY_CLEAR:
                begin
                    run_flag_next = 1'b0;
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        digits_next[i] = 4'd0;
                    end
                end
                default: run_flag_next = run_flag_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_count_reg <= swkd_pkg::TICKS_RESET;
            release_ticks_reg   <= swkd_pkg::RELEASE_RESET;
            scan_position_reg   <= 4'd0;
            press_counter_reg   <= swkd_pkg::PRESS_IDLE;
            latched_key_reg     <= 4'd0;
            key_held_reg        <= 1'b0;
            release_counter_reg <= swkd_pkg::RELEASE_RESET;
            buzzer_enable_reg   <= 1'b0;
            buzzer_state_reg    <= 1'b1;
            run_flag_reg        <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digits_reg[i] <= 4'd0;
            end
            second_counter_reg  <= swkd_pkg::TICKS_RESET;
            second_due_reg      <= 1'b1;
            select_port_reg     <= 4'hf;
            segment_port_reg    <= 8'hff;
            accepted_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    swkd_pkg::REG_TICKS_PER_COUNT: ticks_per_count_reg <= cfg_data;
                    swkd_pkg::REG_RELEASE_TICKS:   release_ticks_reg   <= cfg_data[7:0];
                    default:                       ;
                endcase
            end
            if (accept)
            begin
                scan_position_reg   <= scan_position_reg + 4'd1;
                press_counter_reg   <= press_counter_next;
                latched_key_reg     <= latched_key_next;
                key_held_reg        <= key_held_next;
                release_counter_reg <= release_counter_next;
                buzzer_enable_reg   <= buzzer_enable_next;
                buzzer_state_reg    <= buzzer_state_reg ^ buzzer_enable_reg;
                run_flag_reg        <= run_flag_next;
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    digits_reg[i] <= digits_next[i];
                end
                second_counter_reg  <= second_counter_next;
                second_due_reg      <= 1'b0;
                select_port_reg     <= select_port_next;
                segment_port_reg    <= segment_port_next;
                accepted_reg        <= accepted_next;
                out_valid_reg       <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign digit_select    = select_port_reg;
    assign segment_pattern = segment_port_reg;
    assign buzzer_level    = buzzer_state_reg;
    assign running         = run_flag_reg;
    assign count_bcd       = {bcd_view[3], bcd_view[2], bcd_view[1], bcd_view[0]};
    assign key_accepted    = accepted_reg;
    assign pressed_key     = latched_key_reg;

endmodule
